@@ hdl/xor_checksum_frame_parser_defines.svh @@
// ----------------------------------------------------------------------------
// XOR checksum frame parser: assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKSUM_FRAME_PARSER_DEFINES_SVH
`define XOR_CHECKSUM_FRAME_PARSER_DEFINES_SVH

// generic property check
`define XCFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// signal must not change in the cycle after cond
`define XCFP_ASSERT_HOLD(lbl, cond, sig, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> $stable(sig)) \
      else $error(msg);

`endif

@@ hdl/xcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfp_pkg
// Types and constants shared by the XOR checksum frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcfp_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int FILL_W      = $clog2(MAX_PAYLOAD + 1);

   localparam int DATA_W      = 8;
   localparam int LEN_W       = 7;
   localparam int CNT_W       = 32;
   localparam int IDX_OUT_W   = 6;
   localparam int CSR_IDX_W   = 2;

   localparam logic [DATA_W-1:0] SYNC_FIRST_RST  = 8'd170;
   localparam logic [DATA_W-1:0] SYNC_SECOND_RST = 8'd85;
   localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN     = 2'd2;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_EMPTY     = 2'd1,
      KIND_OVERFLOW  = 2'd2,
      KIND_BAD_CHECK = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      ST_HUNT1 = 7'b0000001,
      ST_HUNT2 = 7'b0000010,
      ST_TYPE  = 7'b0000100,
      ST_LEN   = 7'b0001000,
      ST_DATA  = 7'b0010000,
      ST_CHECK = 7'b0100000,
      ST_DRAIN = 7'b1000000
   } state_type;

endpackage

@@ hdl/xcfp_ram.sv @@
// ----------------------------------------------------------------------------
// xcfp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfp_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/xor_checksum_frame_parser.sv @@
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser
// Two-sync-byte framed stream parser with an 8-bit XOR check and payload store.
// ----------------------------------------------------------------------------
// Results: an event result from a length or check byte appears in the cycle after that byte is taken.
// Throughput: one request per cycle; length and check bytes wait while a result
//   is held. After a good check byte the payload is read back from the store,
//   first byte through the registered read port and the result register, then one
//   per cycle unless results are stalled; requests stall until the last byte is loaded.
// Reset: synchronous; registers and counters return to defaults, store is not cleared.
`timescale 1ns / 1ps

module xor_checksum_frame_parser
   import xcfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [DATA_W-1:0]    req_in_byte,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [DATA_W-1:0]    rsp_frame_type,
   output logic [DATA_W-1:0]    rsp_frame_len,
   output logic [IDX_OUT_W-1:0] rsp_byte_index,
   output logic [DATA_W-1:0]    rsp_data_byte,
   output logic                 rsp_last,
   output logic [CNT_W-1:0]     rsp_overflow_count,
   output logic [CNT_W-1:0]     rsp_checksum_error_count,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] sync1_ff, sync2_ff;
   logic [LEN_W-1:0]  max_len_ff;
   logic [DATA_W-1:0] held_type_ff, held_type_in;
   logic [DATA_W-1:0] held_len_ff, held_len_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [DATA_W-1:0] xor_ff, xor_in;
   logic [CNT_W-1:0]  ovf_ff, ovf_in;
   logic [CNT_W-1:0]  bad_ff, bad_in;
   logic [FILL_W-1:0] rd_idx_ff, rd_idx_in;
   logic              rehunt_ff, rehunt_in;

   logic              out_valid_ff;
   kind_type          out_kind_ff;
   logic [DATA_W-1:0] out_type_ff, out_len_ff, out_data_ff;
   logic [IDX_OUT_W-1:0] out_idx_ff;
   logic              out_last_ff;
   logic [CNT_W-1:0]  out_ovf_ff, out_bad_ff;

   logic              slot_free, req_accept;
   logic [LEN_W-1:0]  limit;
   logic              load;
   kind_type          load_kind;
   logic [FILL_W-1:0] load_idx;
   logic [DATA_W-1:0] load_data;
   logic              load_last;
   logic              ram_we, ram_re;
   logic [DATA_W-1:0] ram_rdata;

   assign slot_free  = !out_valid_ff || !rsp_stall;
   // only the length and check bytes can make a result
   assign req_stall  = (state_ff == ST_DRAIN) ||
                       (!slot_free && ((state_ff == ST_LEN) || (state_ff == ST_CHECK)));
   assign req_accept = req_valid && !req_stall;
   assign limit      = (max_len_ff < LEN_W'(MAX_PAYLOAD)) ? max_len_ff : LEN_W'(MAX_PAYLOAD);

   always_comb begin
      state_in     = state_ff;
      held_type_in = held_type_ff;
      held_len_in  = held_len_ff;
      fill_in      = fill_ff;
      xor_in       = xor_ff;
      ovf_in       = ovf_ff;
      bad_in       = bad_ff;
      rd_idx_in    = rd_idx_ff;
      rehunt_in    = rehunt_ff;
      load         = 1'b0;
      load_kind    = KIND_DATA;
      load_idx     = '0;
      load_data    = '0;
      load_last    = 1'b1;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (req_accept) begin
         unique case (state_ff)
            ST_HUNT1: begin
               state_in = (req_in_byte == sync1_ff) ? ST_HUNT2 : ST_HUNT1;
            end
            ST_HUNT2: begin
               // another first sync byte keeps waiting
               if (req_in_byte == sync2_ff) begin
                  state_in = ST_TYPE;
               end else if (req_in_byte != sync1_ff) begin
                  state_in = ST_HUNT1;
               end
            end
            ST_TYPE: begin
               held_type_in = req_in_byte;
               xor_in       = req_in_byte;
               state_in     = ST_LEN;
            end
            ST_LEN: begin
               held_len_in = req_in_byte;
               xor_in      = xor_ff ^ req_in_byte;
               if (req_in_byte > DATA_W'(limit)) begin
                  ovf_in    = ovf_ff + 1'b1;
                  state_in  = ST_HUNT1;
                  load      = 1'b1;
                  load_kind = KIND_OVERFLOW;
               end else begin
                  fill_in  = '0;
                  state_in = (req_in_byte == '0) ? ST_CHECK : ST_DATA;
               end
            end
            ST_DATA: begin
               ram_we  = (fill_ff < FILL_W'(MAX_PAYLOAD));
               fill_in = fill_ff + 1'b1;
               xor_in  = xor_ff ^ req_in_byte;
               if (DATA_W'(fill_in) >= held_len_ff) begin
                  state_in = ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (req_in_byte == xor_ff) begin
                  if (held_len_ff == '0) begin
                     load      = 1'b1;
                     load_kind = KIND_EMPTY;
                     state_in  = (req_in_byte == sync1_ff) ? ST_HUNT2 : ST_HUNT1;
                  end else begin
                     // start readout at entry 0
                     rehunt_in = (req_in_byte == sync1_ff);
                     rd_idx_in = '0;
                     ram_re    = 1'b1;
                     state_in  = ST_DRAIN;
                  end
               end else begin
                  bad_in    = bad_ff + 1'b1;
                  state_in  = ST_HUNT1;
                  load      = 1'b1;
                  load_kind = KIND_BAD_CHECK;
               end
            end
            default: begin
               state_in = ST_HUNT1;
            end
         endcase
      end

      // readout: read data for rd_idx is on the RAM port, next read overlaps
      if ((state_ff == ST_DRAIN) && slot_free) begin
         load      = 1'b1;
         load_kind = KIND_DATA;
         load_idx  = rd_idx_ff;
         load_data = ram_rdata;
         load_last = ((DATA_W'(rd_idx_ff) + 1'b1) == held_len_ff);
         if (load_last) begin
            state_in = rehunt_ff ? ST_HUNT2 : ST_HUNT1;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
            ram_re    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT1;
         sync1_ff     <= SYNC_FIRST_RST;
         sync2_ff     <= SYNC_SECOND_RST;
         max_len_ff   <= MAX_LEN_RST;
         held_type_ff <= '0;
         held_len_ff  <= '0;
         fill_ff      <= '0;
         xor_ff       <= '0;
         ovf_ff       <= '0;
         bad_ff       <= '0;
         rd_idx_ff    <= '0;
         rehunt_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_type_ff <= held_type_in;
         held_len_ff  <= held_len_in;
         fill_ff      <= fill_in;
         xor_ff       <= xor_in;
         ovf_ff       <= ovf_in;
         bad_ff       <= bad_in;
         rd_idx_ff    <= rd_idx_in;
         rehunt_ff    <= rehunt_in;
         out_valid_ff <= load || (out_valid_ff && rsp_stall);
         if (csr_we) begin
            unique case (csr_index)
               CSR_SYNC_FIRST:  sync1_ff   <= csr_wdata;
               CSR_SYNC_SECOND: sync2_ff   <= csr_wdata;
               CSR_MAX_LEN:     max_len_ff <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_kind_ff <= load_kind;
         out_type_ff <= held_type_in;
         out_len_ff  <= held_len_in;
         out_idx_ff  <= IDX_OUT_W'(load_idx);
         out_data_ff <= load_data;
         out_last_ff <= load_last;
         out_ovf_ff  <= ovf_in;
         out_bad_ff  <= bad_in;
      end
   end

   xcfp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_in_byte),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_in[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rsp_valid                = out_valid_ff;
   assign rsp_kind                 = out_kind_ff;
   assign rsp_frame_type           = out_type_ff;
   assign rsp_frame_len            = out_len_ff;
   assign rsp_byte_index           = out_idx_ff;
   assign rsp_data_byte            = out_data_ff;
   assign rsp_last                 = out_last_ff;
   assign rsp_overflow_count       = out_ovf_ff;
   assign rsp_checksum_error_count = out_bad_ff;

endmodule

@@ hdl/xcfp_checker.sv @@
// ----------------------------------------------------------------------------
// xcfp_checker
// Port-level checks for the XOR checksum frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xor_checksum_frame_parser_defines.svh"

module xcfp_checker
   import xcfp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [DATA_W-1:0]    req_in_byte,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [1:0]           rsp_kind,
   input logic [DATA_W-1:0]    rsp_frame_type,
   input logic [DATA_W-1:0]    rsp_frame_len,
   input logic [IDX_OUT_W-1:0] rsp_byte_index,
   input logic [DATA_W-1:0]    rsp_data_byte,
   input logic                 rsp_last,
   input logic [CNT_W-1:0]     rsp_overflow_count,
   input logic [CNT_W-1:0]     rsp_checksum_error_count,
   input logic                 csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [DATA_W-1:0]    csr_wdata
);

   `XCFP_ASSERT(a_rsp_valid_holds, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped while stalled")
   `XCFP_ASSERT_HOLD(a_rsp_data_holds, rsp_valid && rsp_stall, rsp_data_byte, "stalled rsp_data_byte changed")
   `XCFP_ASSERT(a_event_shape, rsp_valid && (rsp_kind != KIND_DATA) |-> rsp_last && (rsp_byte_index == '0) && (rsp_data_byte == '0), "event result not a single zeroed item")
   `XCFP_ASSERT(a_readout_blocks, rsp_valid && (rsp_kind == KIND_DATA) && !rsp_last |-> req_stall, "request taken during payload readout")
   `XCFP_ASSERT(a_readout_steps, rsp_valid && (rsp_kind == KIND_DATA) && !rsp_last && !rsp_stall |=> rsp_valid && (rsp_kind == KIND_DATA) && (rsp_byte_index == $past(rsp_byte_index) + 1'b1), "payload readout skipped a byte")

endmodule

bind xor_checksum_frame_parser xcfp_checker u_xcfp_checker (.*);
